// ----- hdl/cmf_pkg.sv -----
// ----------------------------------------------------------------------------
// cmf_pkg
// Shared types and constants of the cross morphology filter: sizes, the
// configuration set, the payload structs and the records passed between units.
// ----------------------------------------------------------------------------
package cmf_pkg;

  // Frame size limits.
  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 4096;

  // Counter and size widths derived from the limits.
  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int WID_W = $clog2(MAX_WIDTH + 1);
  localparam int ROW_W = $clog2(MAX_HEIGHT + 1);

  // Configuration register widths and write port.
  localparam int CFG_WIDTH_W  = 11;
  localparam int CFG_HEIGHT_W = 13;
  localparam int CFG_DATA_W   = 13;
  localparam int CFG_INDEX_W  = 3;

  localparam logic [CFG_WIDTH_W-1:0]  WIDTH_RESET  = CFG_WIDTH_W'(1024);
  localparam logic [CFG_HEIGHT_W-1:0] HEIGHT_RESET = CFG_HEIGHT_W'(4096);

  // Queue between the front and the back.
  localparam int QDEPTH  = 4;
  localparam int QPTR_W  = $clog2(QDEPTH);
  localparam int LEVEL_W = $clog2(QDEPTH + 1);

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_MODE       = 3'd0,
    REG_FOREGROUND = 3'd1,
    REG_BACKGROUND = 3'd2,
    REG_WIDTH      = 3'd3,
    REG_HEIGHT     = 3'd4
  } cfg_reg_t;

  typedef enum logic {
    MODE_DILATE = 1'b0,
    MODE_ERODE  = 1'b1
  } mode_t;

  typedef enum logic {
    KIND_PIXEL = 1'b0,
    KIND_DRAIN = 1'b1
  } kind_t;

  typedef struct packed {
    logic                    mode;
    logic [7:0]              foreground_code;
    logic [7:0]              background_code;
    logic [CFG_WIDTH_W-1:0]  image_width;
    logic [CFG_HEIGHT_W-1:0] image_height;
  } cfg_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] pixel_in;
  } in_item_t;

  typedef struct packed {
    logic [7:0] pixel_out;
    logic       last_of_frame;
  } out_item_t;

  // Request to the line buffer. Port A reads (and writes) column c, port B reads
  // column c+1 (c at a row end); up_bank selects the bank of the row above.
  typedef struct packed {
    logic             rd_en;
    logic             wr_en;
    logic             up_bank;
    logic [COL_W-1:0] addr_a;
    logic [COL_W-1:0] addr_b;
    logic [7:0]       wr_data;
  } lb_req_t;

  typedef struct packed {
    logic [7:0] up;
    logic [7:0] center;
    logic [7:0] right;
  } lb_rsp_t;

  // One classified window, ready for the filter.
  typedef struct packed {
    logic [7:0] center;
    logic [7:0] up;
    logic [7:0] down;
    logic [7:0] left;
    logic [7:0] right;
    logic       has_up;
    logic       has_down;
    logic       has_left;
    logic       has_right;
    logic       last;
  } qent_t;

endpackage

// ----- hdl/cmf_line_buf.sv -----
// ----------------------------------------------------------------------------
// cmf_line_buf
// Two row banks selected by row parity. Each bank is read at two columns and
// written at one; read data is registered and old data is returned on a read
// of the column being written.
// ----------------------------------------------------------------------------
module cmf_line_buf (
  input  logic             clk,
  input  cmf_pkg::lb_req_t req,
  output cmf_pkg::lb_rsp_t rsp
);
  import cmf_pkg::*;

  logic [7:0] bank0 [MAX_WIDTH];
  logic [7:0] bank1 [MAX_WIDTH];
  logic [7:0] b0_a, b0_b, b1_a, b1_b;
  logic       up_sel;

  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      b0_a   <= bank0[req.addr_a];
      b0_b   <= bank0[req.addr_b];
      up_sel <= req.up_bank;
    end
    if (req.wr_en && !req.up_bank) begin
      bank0[req.addr_a] <= req.wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      b1_a <= bank1[req.addr_a];
      b1_b <= bank1[req.addr_b];
    end
    if (req.wr_en && req.up_bank) begin
      bank1[req.addr_a] <= req.wr_data;
    end
  end

  always_comb begin
    rsp.up     = up_sel ? b1_a : b0_a;
    rsp.center = up_sel ? b0_a : b1_a;
    rsp.right  = up_sel ? b0_b : b1_b;
  end

endmodule

// ----- hdl/cmf_front.sv -----
// ----------------------------------------------------------------------------
// cmf_front
// Accepts items, tracks the raster position, classifies each item (pixel,
// drain, ignored), drives the line buffer and builds the window record.
// ----------------------------------------------------------------------------
module cmf_front (
  input  logic                         clk,
  input  logic                         rst,
  input  cmf_pkg::cfg_t                cfg,
  input  logic                         item_valid,
  output logic                         item_stall,
  input  cmf_pkg::in_item_t            item,
  input  logic [cmf_pkg::LEVEL_W-1:0]  q_level,
  output cmf_pkg::lb_req_t             lb_req,
  input  cmf_pkg::lb_rsp_t             lb_rsp,
  output logic                         q_push,
  output cmf_pkg::qent_t               q_entry
);
  import cmf_pkg::*;

  logic [COL_W-1:0] in_column;
  logic [ROW_W-1:0] in_row;
  logic [WID_W-1:0] w_eff;
  logic [ROW_W-1:0] h_eff;
  logic [WID_W-1:0] col_next;
  logic             row_end;
  logic             draining;
  logic             is_pixel;
  logic             emit;
  logic             accept;

  // Window stage, aligned with the registered line buffer data.
  logic       s1_valid;
  logic       s1_has_up, s1_has_down, s1_has_left, s1_has_right, s1_last;
  logic [7:0] s1_down;
  logic [7:0] prev_center;

  always_comb begin
    if (cfg.image_width == '0) begin
      w_eff = WID_W'(1);
    end else if (32'(cfg.image_width) > MAX_WIDTH) begin
      w_eff = WID_W'(MAX_WIDTH);
    end else begin
      w_eff = WID_W'(cfg.image_width);
    end
    if (cfg.image_height == '0) begin
      h_eff = ROW_W'(1);
    end else if (32'(cfg.image_height) > MAX_HEIGHT) begin
      h_eff = ROW_W'(MAX_HEIGHT);
    end else begin
      h_eff = ROW_W'(cfg.image_height);
    end
  end

  always_comb begin
    col_next   = WID_W'(in_column) + WID_W'(1);
    row_end    = col_next >= w_eff;
    draining   = in_row >= h_eff;
    is_pixel   = (item.kind == KIND_PIXEL) && !draining;
    emit       = draining || (is_pixel && (in_row != '0));
    item_stall = (LEVEL_W'(q_level) + LEVEL_W'(s1_valid)) >= LEVEL_W'(QDEPTH);
    accept     = item_valid && !item_stall;
  end

  always_comb begin
    lb_req.rd_en   = accept && emit;
    lb_req.wr_en   = accept && is_pixel;
    lb_req.up_bank = in_row[0];
    lb_req.addr_a  = in_column;
    lb_req.addr_b  = row_end ? in_column : COL_W'(col_next);
    lb_req.wr_data = item.pixel_in;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_column <= '0;
      in_row    <= '0;
      s1_valid  <= 1'b0;
    end else begin
      s1_valid <= accept && emit;
      if (accept && (draining || is_pixel)) begin
        if (row_end) begin
          in_column <= '0;
          in_row    <= draining ? '0 : in_row + ROW_W'(1);
        end else begin
          in_column <= in_column + COL_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      s1_has_up    <= in_row >= ROW_W'(2);
      s1_has_down  <= !draining;
      s1_has_left  <= in_column != '0;
      s1_has_right <= !row_end;
      s1_last      <= draining && row_end;
      s1_down      <= item.pixel_in;
    end
    // The left neighbour is the centre of the previous window in the row.
    if (s1_valid) begin
      prev_center <= lb_rsp.center;
    end
  end

  always_comb begin
    q_push            = s1_valid;
    q_entry.center    = lb_rsp.center;
    q_entry.up        = lb_rsp.up;
    q_entry.down      = s1_down;
    q_entry.left      = prev_center;
    q_entry.right     = lb_rsp.right;
    q_entry.has_up    = s1_has_up;
    q_entry.has_down  = s1_has_down;
    q_entry.has_left  = s1_has_left;
    q_entry.has_right = s1_has_right;
    q_entry.last      = s1_last;
  end

endmodule

// ----- hdl/cmf_queue.sv -----
// ----------------------------------------------------------------------------
// cmf_queue
// Short first-in first-out queue of window records between front and back.
// ----------------------------------------------------------------------------
module cmf_queue (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  input  cmf_pkg::qent_t               push_data,
  input  logic                         pop,
  output cmf_pkg::qent_t               head,
  output logic                         not_empty,
  output logic [cmf_pkg::LEVEL_W-1:0]  level
);
  import cmf_pkg::*;

  qent_t             entries [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic              do_pop;

  assign do_pop    = pop && (level != '0);
  assign not_empty = level != '0;
  assign head      = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      end
      if (push && !do_pop) begin
        level <= level + LEVEL_W'(1);
      end else if (!push && do_pop) begin
        level <= level - LEVEL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

// ----- hdl/cmf_back.sv -----
// ----------------------------------------------------------------------------
// cmf_back
// Applies dilation or erosion to the window at the head of the queue and
// holds the result in the output register until it is taken.
// ----------------------------------------------------------------------------
module cmf_back (
  input  logic               clk,
  input  logic               rst,
  input  cmf_pkg::cfg_t      cfg,
  input  cmf_pkg::qent_t     q_head,
  input  logic               q_not_empty,
  output logic               q_pop,
  output logic               result_valid,
  input  logic               result_stall,
  output cmf_pkg::out_item_t result
);
  import cmf_pkg::*;

  logic [7:0] want;
  logic       hit;
  logic [7:0] filtered;
  logic       take;

  always_comb begin
    want = (cfg.mode == MODE_ERODE) ? cfg.background_code : cfg.foreground_code;
    hit  = (q_head.has_up    && (q_head.up    == want)) ||
           (q_head.has_down  && (q_head.down  == want)) ||
           (q_head.has_left  && (q_head.left  == want)) ||
           (q_head.has_right && (q_head.right == want));
    if (cfg.mode == MODE_ERODE) begin
      filtered = ((q_head.center == cfg.foreground_code) && hit) ?
                 cfg.background_code : q_head.center;
    end else begin
      filtered = ((q_head.center == cfg.foreground_code) || hit) ?
                 cfg.foreground_code : q_head.center;
    end
    take  = !result_valid || !result_stall;
    q_pop = q_not_empty && take;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (take) begin
      result_valid <= q_not_empty;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      result.pixel_out     <= filtered;
      result.last_of_frame <= q_head.last;
    end
  end

endmodule

// ----- hdl/cross_morphology_filter_unit.sv -----
// ----------------------------------------------------------------------------
// cross_morphology_filter_unit
// Cross shaped (4-neighbour) binary dilation or erosion of a character image
// streamed in raster order, one byte per transaction.
// ----------------------------------------------------------------------------
// Usage:
//   The item channel (item_valid / item_stall / item) carries one pixel per
//   transaction, or a drain tick. The result channel (result_valid /
//   result_stall / result) returns the filtered pixels in raster order, the
//   final one of the frame marked by last_of_frame.
//   The result for a pixel is released by the pixel directly below it, so
//   rows 1..H-1 of the input release rows 0..H-2 of the output; after the
//   last pixel, one drain tick (or pixel) per column flushes the final row.
//   A released result passes the window stage register, the queue and the
//   output register. One transaction per cycle is sustained unless stalled;
//   the line buffer reads the current column and its right neighbour for
//   each releasing transaction. The configuration port (cfg_we / cfg_index /
//   cfg_data) is to be written by the user only while no transaction is in
//   progress, which the block does not enforce; a write takes effect the
//   next cycle. Reset (synchronous, active high) returns the raster position
//   to the frame start, empties the queue and output register, and loads the
//   register reset values. Line buffer contents are not cleared. When the
//   receiver stalls, the held result stays on the port, up to four windows
//   collect in the queue, and item_stall then rises until space frees up.
// ----------------------------------------------------------------------------
module cross_morphology_filter_unit (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            item_valid,
  output logic                            item_stall,
  input  cmf_pkg::in_item_t               item,
  output logic                            result_valid,
  input  logic                            result_stall,
  output cmf_pkg::out_item_t              result,
  input  logic                            cfg_we,
  input  logic [cmf_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [cmf_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import cmf_pkg::*;

  // Configuration registers. Unlisted indexes are ignored.
  cfg_t cfg;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode            <= MODE_DILATE;
      cfg.foreground_code <= '0;
      cfg.background_code <= '0;
      cfg.image_width     <= WIDTH_RESET;
      cfg.image_height    <= HEIGHT_RESET;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_MODE:       cfg.mode            <= cfg_data[0];
        REG_FOREGROUND: cfg.foreground_code <= cfg_data[7:0];
        REG_BACKGROUND: cfg.background_code <= cfg_data[7:0];
        REG_WIDTH:      cfg.image_width     <= cfg_data[CFG_WIDTH_W-1:0];
        REG_HEIGHT:     cfg.image_height    <= cfg_data[CFG_HEIGHT_W-1:0];
        default:        ;
      endcase
    end
  end

  lb_req_t              lb_req;
  lb_rsp_t              lb_rsp;
  logic                 q_push;
  qent_t                q_entry;
  logic                 q_pop;
  qent_t                q_head;
  logic                 q_not_empty;
  logic [LEVEL_W-1:0]   q_level;

  // The front classifies items and reads the line buffer; the window record
  // is pushed into the queue in the next cycle, alongside the read data.
  cmf_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item       (item),
    .q_level    (q_level),
    .lb_req     (lb_req),
    .lb_rsp     (lb_rsp),
    .q_push     (q_push),
    .q_entry    (q_entry)
  );

  cmf_line_buf u_line_buf (
    .clk (clk),
    .req (lb_req),
    .rsp (lb_rsp)
  );

  cmf_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_entry),
    .pop       (q_pop),
    .head      (q_head),
    .not_empty (q_not_empty),
    .level     (q_level)
  );

  // The back filters the head window into the output register.
  cmf_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .q_head       (q_head),
    .q_not_empty  (q_not_empty),
    .q_pop        (q_pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

// ----- hdl/cmf_checker.sv -----
// ----------------------------------------------------------------------------
// cmf_checker
// Port level checks of the cross morphology filter, bound to the top level.
// ----------------------------------------------------------------------------
module cmf_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            item_valid,
  input logic                            item_stall,
  input cmf_pkg::in_item_t               item,
  input logic                            result_valid,
  input logic                            result_stall,
  input cmf_pkg::out_item_t              result,
  input logic                            cfg_we,
  input logic [cmf_pkg::CFG_INDEX_W-1:0] cfg_index,
  input logic [cmf_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import cmf_pkg::*;

  // A stalled result stays on the port unchanged.
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("result changed while stalled");

  // Reset leaves no result pending.
  a_reset_clears_result: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result pending after reset");

  // Reset leaves the item channel open.
  a_reset_opens_input: assert property (@(posedge clk)
    rst |=> !item_stall)
    else $error("item channel stalled after reset");

  // With nothing waiting at the output, the queue cannot be full.
  a_no_stall_when_drained: assert property (@(posedge clk) disable iff (rst)
    !result_valid |-> !item_stall)
    else $error("item channel stalled while the output is empty");

endmodule

bind cross_morphology_filter_unit cmf_checker u_checker (.*);
